// ===== src/gsps_pkg.sv =====
// ----------------------------------------------------------------------------
// gsps_pkg: shared types and constants of the golden-section peak search
// Micro-op and condition codes, the microcode table, field widths and the
// 1/phi constant in Q0.32.
// ----------------------------------------------------------------------------
`default_nettype none

package gsps_pkg;

  localparam int CFG_W     = 21;
  localparam int VAL_W     = 32;
  localparam int KIND_W    = 2;
  localparam int OUT_POS_W = 21;
  localparam int STEP_W    = 4;

  localparam logic [31:0] INV_PHI_Q32 = 32'h9E3779B9;
  localparam logic [VAL_W-1:0] ABORT_VALUE = 32'hFFFFFFFF;

  localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT  = 2'd2;

  // Microcode step addresses.
  localparam logic [STEP_W-1:0] ST_WAIT       = 4'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH   = 4'd1;
  localparam logic [STEP_W-1:0] ST_IDLE_CHK   = 4'd2;
  localparam logic [STEP_W-1:0] ST_ABORT_CHK  = 4'd3;
  localparam logic [STEP_W-1:0] ST_FOLD_RESP  = 4'd4;
  localparam logic [STEP_W-1:0] ST_TEST_MUL   = 4'd5;
  localparam logic [STEP_W-1:0] ST_MEAN       = 4'd6;
  localparam logic [STEP_W-1:0] ST_RANGE_CHK  = 4'd7;
  localparam logic [STEP_W-1:0] ST_FOLD_ZERO  = 4'd8;
  localparam logic [STEP_W-1:0] ST_ANSWER     = 4'd9;
  localparam logic [STEP_W-1:0] ST_ABORT      = 4'd10;
  localparam logic [STEP_W-1:0] ST_INIT       = 4'd11;
  localparam logic [STEP_W-1:0] ST_PROBE      = 4'd12;
  localparam logic [STEP_W-1:0] ST_START_MUL  = 4'd13;
  localparam logic [STEP_W-1:0] ST_START_SET  = 4'd14;
  localparam logic [STEP_W-1:0] ST_START_EMIT = 4'd15;

  typedef enum logic [3:0] {
    U_ACCEPT      = 4'd0,
    U_NOP         = 4'd1,
    U_FOLD_RESP   = 4'd2,
    U_MUL         = 4'd3,
    U_MEAN        = 4'd4,
    U_FOLD_ZERO   = 4'd5,
    U_EMIT_ANSWER = 4'd6,
    U_EMIT_ABORT  = 4'd7,
    U_INIT        = 4'd8,
    U_EMIT_PROBE  = 4'd9,
    U_START_SET   = 4'd10,
    U_EMIT_START  = 4'd11
  } uop_t;

  typedef enum logic [2:0] {
    C_NONE  = 3'd0,
    C_START = 3'd1,
    C_IDLE  = 3'd2,
    C_ABORT = 3'd3,
    C_DONE  = 3'd4,
    C_YOUT  = 3'd5
  } cond_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SEARCH = 3'b100
  } phase_t;

  typedef struct packed {
    uop_t              uop;
    cond_t             cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
  } ucode_t;

  // Status from the datapath that steers the sequencer.
  typedef struct packed {
    logic hold;
    logic is_start;
    logic is_idle;
    logic is_abort;
    logic is_done;
    logic y_out;
  } flags_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      ST_WAIT:       w = '{U_ACCEPT,      C_NONE,  ST_WAIT,      ST_DISPATCH};
      ST_DISPATCH:   w = '{U_NOP,         C_START, ST_INIT,      ST_IDLE_CHK};
      ST_IDLE_CHK:   w = '{U_NOP,         C_IDLE,  ST_WAIT,      ST_ABORT_CHK};
      ST_ABORT_CHK:  w = '{U_NOP,         C_ABORT, ST_ABORT,     ST_FOLD_RESP};
      ST_FOLD_RESP:  w = '{U_FOLD_RESP,   C_NONE,  ST_WAIT,      ST_TEST_MUL};
      ST_TEST_MUL:   w = '{U_MUL,         C_DONE,  ST_ANSWER,    ST_MEAN};
      ST_MEAN:       w = '{U_MEAN,        C_NONE,  ST_WAIT,      ST_RANGE_CHK};
      ST_RANGE_CHK:  w = '{U_NOP,         C_YOUT,  ST_FOLD_ZERO, ST_PROBE};
      ST_FOLD_ZERO:  w = '{U_FOLD_ZERO,   C_NONE,  ST_WAIT,      ST_TEST_MUL};
      ST_ANSWER:     w = '{U_EMIT_ANSWER, C_NONE,  ST_WAIT,      ST_WAIT};
      ST_ABORT:      w = '{U_EMIT_ABORT,  C_NONE,  ST_WAIT,      ST_WAIT};
      ST_INIT:       w = '{U_INIT,        C_NONE,  ST_WAIT,      ST_START_MUL};
      ST_PROBE:      w = '{U_EMIT_PROBE,  C_NONE,  ST_WAIT,      ST_WAIT};
      ST_START_MUL:  w = '{U_MUL,         C_NONE,  ST_WAIT,      ST_START_SET};
      ST_START_SET:  w = '{U_START_SET,   C_NONE,  ST_WAIT,      ST_START_EMIT};
      ST_START_EMIT: w = '{U_EMIT_START,  C_NONE,  ST_WAIT,      ST_WAIT};
      default:       w = '{U_NOP,         C_NONE,  ST_WAIT,      ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/golden_section_peak_search.sv =====
// ----------------------------------------------------------------------------
// golden_section_peak_search: interactive integer golden-section peak search
// Searches positions 1..search_size for a local maximum, asking the host for
// values one probe at a time.
// ----------------------------------------------------------------------------
// Usage: write search_size on the cfg channel while idle. An input transfer
// with in_tuser 0 starts a search; with in_tuser 1 it carries the value at the
// last requested position in in_tdata (-1 aborts). Each accepted start or
// live response yields one result: a probe request (kind 0), the answer
// (kind 1) or an abort notice (kind 2). A response while idle yields nothing.
// A microcoded sequencer runs one control word per cycle while it is not held
// in the wait step for input, so timing is set by the program length. A probe
// that falls outside 1..size is folded in internally before the next probe or
// the answer is emitted.
// Only one item is in work at a time; in_tready is high in the wait step.
// The result register lets the next item be accepted while a result waits.
// When the receiver stalls, the sequencer holds at its next emit step.
// Reset (synchronous, rst_n low) returns to idle with search_size 1.
// ----------------------------------------------------------------------------
`default_nettype none

module golden_section_peak_search #(
  parameter int POSITION_BITS = 20
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] probe_value
  input  wire  [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [20:0] position, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [20:0] cfg_data
);

  gsps_pkg::uop_t   uop;
  gsps_pkg::flags_t flags;
  logic [gsps_pkg::OUT_POS_W-1:0] out_pos;

  gsps_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uop   (uop)
  );

  gsps_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .uop        (uop),
    .flags      (flags),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pos    (out_pos),
    .out_kind   (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data)
  );

  assign out_tdata = {3'b000, out_pos};
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== src/gsps_sequencer.sv =====
// ----------------------------------------------------------------------------
// gsps_sequencer: microcode step counter
// Holds the step address, reads the control word from the microcode table
// and picks the next step from the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module gsps_sequencer (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire gsps_pkg::flags_t flags,
  output gsps_pkg::uop_t        uop
);

  logic [gsps_pkg::STEP_W-1:0] step_r;
  logic [gsps_pkg::STEP_W-1:0] step_nxt;
  gsps_pkg::ucode_t            word;
  logic                        taken;

  assign word = gsps_pkg::ucode_rom(step_r);
  assign uop  = word.uop;

  always_comb begin
    case (word.cond)
      gsps_pkg::C_START: taken = flags.is_start;
      gsps_pkg::C_IDLE:  taken = flags.is_idle;
      gsps_pkg::C_ABORT: taken = flags.is_abort;
      gsps_pkg::C_DONE:  taken = flags.is_done;
      gsps_pkg::C_YOUT:  taken = flags.y_out;
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    if (flags.hold) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = word.jmp;
    end else begin
      step_nxt = word.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= gsps_pkg::ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/gsps_datapath.sv =====
// ----------------------------------------------------------------------------
// gsps_datapath: interval registers, golden-point arithmetic and channels
// Executes one micro-op per cycle: input capture, the 1/phi multiply, the
// mirrored golden point, the fold of a probed value and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsps_datapath #(
  parameter int POSITION_BITS = 20
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire gsps_pkg::uop_t                 uop,
  output gsps_pkg::flags_t                    flags,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [gsps_pkg::VAL_W-1:0]          in_tdata,
  input  wire                                 in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [gsps_pkg::OUT_POS_W-1:0]      out_pos,
  output logic [gsps_pkg::KIND_W-1:0]         out_kind,
  input  wire                                 cfg_valid,
  input  wire  [gsps_pkg::CFG_W-1:0]          cfg_data
);

  localparam int PW = POSITION_BITS + 1;
  localparam int NW = (PW > gsps_pkg::CFG_W) ? PW : gsps_pkg::CFG_W;

  logic [gsps_pkg::CFG_W-1:0]  size_r;
  logic                        mode_r;
  logic [gsps_pkg::VAL_W-1:0]  val_r;
  logic [PW-1:0]               lo_r;
  logic [PW-1:0]               hi_r;
  logic [PW-1:0]               best_r;
  logic [gsps_pkg::VAL_W-1:0]  bval_r;
  logic [PW-1:0]               probe_r;
  logic [PW-1:0]               off_r;
  gsps_pkg::phase_t            phase_r;
  logic                        out_valid_r;
  logic [gsps_pkg::KIND_W-1:0] out_kind_r;
  logic [gsps_pkg::OUT_POS_W-1:0] out_pos_r;

  logic [NW-1:0]      size_ext;
  logic [NW-1:0]      cap_ext;
  logic [NW-1:0]      n_ext;
  logic [PW-1:0]      n;
  logic [PW-1:0]      len;
  logic [PW+31:0]     prod;
  logic [PW:0]        sum_ab;
  logic [PW:0]        y_gold;
  logic [PW:0]        y_mirror;
  logic [PW:0]        y_final;
  logic [PW-1:0]      fy_pos;
  logic [gsps_pkg::VAL_W-1:0] fy_val;
  logic               swap;
  logic [PW-1:0]      lx;
  logic [PW-1:0]      hx;
  logic [gsps_pkg::VAL_W-1:0] lf;
  logic [gsps_pkg::VAL_W-1:0] hf;
  logic               keep_high;
  logic               out_space;
  logic               is_emit;
  logic               in_fire;

  // Clamp the configured size to 1..2^POSITION_BITS.
  assign size_ext = NW'(size_r);
  assign cap_ext  = NW'(1) << POSITION_BITS;
  always_comb begin
    if (size_ext == '0) begin
      n_ext = NW'(1);
    end else if (size_ext > cap_ext) begin
      n_ext = cap_ext;
    end else begin
      n_ext = size_ext;
    end
  end
  assign n = n_ext[PW-1:0];

  assign len  = hi_r - lo_r + PW'(1);
  assign prod = (PW+32)'(len) * (PW+32)'(gsps_pkg::INV_PHI_Q32);

  // Golden point of [lo, hi], mirrored to the side away from the best point.
  always_comb begin
    sum_ab   = {1'b0, lo_r} + {1'b0, hi_r};
    y_gold   = {1'b0, lo_r} + {1'b0, off_r};
    y_mirror = ({best_r, 1'b0} > sum_ab) ? (sum_ab - y_gold) : y_gold;
    y_final  = ({1'b0, best_r} == y_mirror) ? (y_mirror + (PW+1)'(1)) : y_mirror;
  end

  // Fold a probed point into the interval, ordered by position.
  always_comb begin
    fy_pos = probe_r;
    fy_val = (uop == gsps_pkg::U_FOLD_ZERO) ? '0 : val_r;
    swap   = best_r > fy_pos;
    lx     = swap ? fy_pos : best_r;
    lf     = swap ? fy_val : bval_r;
    hx     = swap ? best_r : fy_pos;
    hf     = swap ? bval_r : fy_val;
    keep_high = $signed(lf) <= $signed(hf);
  end

  assign out_space = !out_valid_r || out_tready;
  assign is_emit   = (uop == gsps_pkg::U_EMIT_ANSWER) || (uop == gsps_pkg::U_EMIT_ABORT) ||
                     (uop == gsps_pkg::U_EMIT_PROBE) || (uop == gsps_pkg::U_EMIT_START);
  assign in_tready = (uop == gsps_pkg::U_ACCEPT);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    flags.hold     = (in_tready && !in_tvalid) || (is_emit && !out_space);
    flags.is_start = !mode_r;
    flags.is_idle  = (phase_r == gsps_pkg::PH_IDLE);
    flags.is_abort = (val_r == gsps_pkg::ABORT_VALUE);
    flags.is_done  = lo_r >= hi_r;
    flags.y_out    = (probe_r == '0) || (probe_r > n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= gsps_pkg::CFG_W'(1);
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_tuser;
      val_r  <= in_tdata;
    end
    if (uop == gsps_pkg::U_MUL) begin
      off_r <= prod[PW+31:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= PW'(1);
      hi_r    <= PW'(1);
      best_r  <= '0;
      bval_r  <= '0;
      probe_r <= '0;
      phase_r <= gsps_pkg::PH_IDLE;
    end else begin
      case (uop)
        gsps_pkg::U_INIT: begin
          lo_r <= PW'(1);
          hi_r <= n;
        end
        gsps_pkg::U_START_SET: begin
          probe_r <= lo_r + off_r;
          best_r  <= lo_r + off_r;
          bval_r  <= '0;
        end
        gsps_pkg::U_FOLD_RESP, gsps_pkg::U_FOLD_ZERO: begin
          if (uop == gsps_pkg::U_FOLD_RESP && phase_r == gsps_pkg::PH_FIRST) begin
            best_r <= probe_r;
            bval_r <= val_r;
          end else if (keep_high) begin
            lo_r   <= lx + PW'(1);
            best_r <= hx;
            bval_r <= hf;
          end else begin
            hi_r   <= hx - PW'(1);
            best_r <= lx;
            bval_r <= lf;
          end
        end
        gsps_pkg::U_MEAN: begin
          probe_r <= y_final[PW-1:0];
        end
        gsps_pkg::U_EMIT_START: begin
          if (out_space) phase_r <= gsps_pkg::PH_FIRST;
        end
        gsps_pkg::U_EMIT_PROBE: begin
          if (out_space) phase_r <= gsps_pkg::PH_SEARCH;
        end
        gsps_pkg::U_EMIT_ANSWER, gsps_pkg::U_EMIT_ABORT: begin
          if (out_space) phase_r <= gsps_pkg::PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: a new result loads as the previous one transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_emit && out_space) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit && out_space) begin
      case (uop)
        gsps_pkg::U_EMIT_ANSWER: begin
          out_kind_r <= gsps_pkg::KIND_ANSWER;
          out_pos_r  <= gsps_pkg::OUT_POS_W'(best_r);
        end
        gsps_pkg::U_EMIT_ABORT: begin
          out_kind_r <= gsps_pkg::KIND_ABORT;
          out_pos_r  <= '0;
        end
        default: begin
          out_kind_r <= gsps_pkg::KIND_PROBE;
          out_pos_r  <= gsps_pkg::OUT_POS_W'(probe_r);
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_pos    = out_pos_r;

endmodule

`default_nettype wire

// ===== src/gsps_checker.sv =====
// ----------------------------------------------------------------------------
// gsps_checker: port-level checks for the golden-section peak search
// Watches the top-level channels and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module gsps_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire [1:0]  out_tuser
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Items are worked one at a time, so ready drops after each input transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == gsps_pkg::KIND_PROBE || out_tuser == gsps_pkg::KIND_ANSWER ||
                    out_tuser == gsps_pkg::KIND_ABORT))
    else $error("unknown result kind");

  a_abort_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gsps_pkg::KIND_ABORT |-> out_tdata == 24'd0)
    else $error("abort notice with a nonzero position");

  // Probes are only requested inside 1..size; this checks the lower bound and the zero top bits.
  a_probe_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gsps_pkg::KIND_PROBE |->
      out_tdata[20:0] != 21'd0 && out_tdata[23:21] == 3'd0)
    else $error("probe request outside the search range");

endmodule

bind golden_section_peak_search gsps_checker u_gsps_checker (.*);

`default_nettype wire

// ===== bench/golden_section_peak_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golden_section_peak_search_checker: result predictor and scoreboard
// Watches the configuration, input and result channels of the peak search.
// A behavioral copy of the search state predicts the result of every input
// transfer. Each result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------

module golden_section_peak_search_checker #(
  parameter int POSITION_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] probe_value
  input  logic [0:0]  in_tuser,   // [0] mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [20:0] position, [23:21] zero
  input  logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [20:0] cfg_data,
  output int          mismatch_count,
  output int          pending_count,
  output int          probes_seen,
  output int          answers_seen,
  output int          aborts_seen,
  output int          folds_predicted
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [gsps_pkg::KIND_W-1:0]    kind;
    logic [gsps_pkg::OUT_POS_W-1:0] position;
  } search_result_t;

  search_result_t expected_results[$];

  logic [gsps_pkg::CFG_W-1:0]     size_reg;
  logic [gsps_pkg::OUT_POS_W-1:0] lo_pos;
  logic [gsps_pkg::OUT_POS_W-1:0] hi_pos;
  logic [gsps_pkg::OUT_POS_W-1:0] best_pos;
  logic [gsps_pkg::VAL_W-1:0]     best_val;
  logic [gsps_pkg::OUT_POS_W-1:0] probe_pos;
  gsps_pkg::phase_t               search_phase;
  int                             fail_tally;
  int                             fold_tally;
  int                             probe_tally;
  int                             answer_tally;
  int                             abort_tally;

  function automatic logic [63:0] effective_size();
    logic [63:0] cap;
    logic [63:0] n;
    cap = 64'd1 << POSITION_BITS;
    n = {43'd0, size_reg};
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  // The divide by phi is a Q0.32 multiply by 1/phi with the product truncated.
  function automatic logic [63:0] golden_point(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] len;
    len = b - a + 1;
    return a + ((len * {32'd0, gsps_pkg::INV_PHI_Q32}) >> 32);
  endfunction

  // Keep the better of the best point and the new point, drop past the worse.
  task automatic fold_point(input logic [gsps_pkg::OUT_POS_W-1:0] y,
                            input logic [gsps_pkg::VAL_W-1:0] fy);
    logic [gsps_pkg::OUT_POS_W-1:0] lx;
    logic [gsps_pkg::OUT_POS_W-1:0] hx;
    logic [gsps_pkg::VAL_W-1:0]     lf;
    logic [gsps_pkg::VAL_W-1:0]     hf;
    lx = best_pos;
    lf = best_val;
    hx = y;
    hf = fy;
    if (lx > hx) begin
      lx = y;
      lf = fy;
      hx = best_pos;
      hf = best_val;
    end
    if ($signed(lf) <= $signed(hf)) begin
      lo_pos = lx + 1'b1;
      best_pos = hx;
      best_val = hf;
    end else begin
      hi_pos = hx - 1'b1;
      best_pos = lx;
      best_val = lf;
    end
  endtask

  // Probes that fall outside 1..size are folded in as value 0 until a probe
  // inside the range or a single-point interval is reached.
  task automatic next_probe(output search_result_t r);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] y;
    bit          done;
    done = 0;
    r = '0;
    while (!done) begin
      a = {43'd0, lo_pos};
      b = {43'd0, hi_pos};
      x = {43'd0, best_pos};
      if (a >= b) begin
        r.kind = gsps_pkg::KIND_ANSWER;
        r.position = x[gsps_pkg::OUT_POS_W-1:0];
        search_phase = gsps_pkg::PH_IDLE;
        done = 1;
      end else begin
        y = golden_point(a, b);
        if (2 * x > a + b) y = a + b - y;
        if (x == y) y = y + 1;
        probe_pos = y[gsps_pkg::OUT_POS_W-1:0];
        if (y < 1 || y > effective_size()) begin
          fold_point(y[gsps_pkg::OUT_POS_W-1:0], '0);
          fold_tally++;
        end else begin
          r.kind = gsps_pkg::KIND_PROBE;
          r.position = y[gsps_pkg::OUT_POS_W-1:0];
          search_phase = gsps_pkg::PH_SEARCH;
          done = 1;
        end
      end
    end
  endtask

  task automatic predict_item(input logic mode, input logic [gsps_pkg::VAL_W-1:0] v,
                              output bit produced, output search_result_t r);
    logic [63:0] n;
    logic [63:0] g;
    produced = 0;
    r = '0;
    if (mode == 1'b0) begin
      n = effective_size();
      g = golden_point(64'd1, n);
      lo_pos = 1;
      hi_pos = n[gsps_pkg::OUT_POS_W-1:0];
      probe_pos = g[gsps_pkg::OUT_POS_W-1:0];
      best_pos = g[gsps_pkg::OUT_POS_W-1:0];
      best_val = '0;
      search_phase = gsps_pkg::PH_FIRST;
      r.kind = gsps_pkg::KIND_PROBE;
      r.position = g[gsps_pkg::OUT_POS_W-1:0];
      produced = 1;
    end else if (search_phase == gsps_pkg::PH_FIRST ||
                 search_phase == gsps_pkg::PH_SEARCH) begin
      produced = 1;
      if (v == gsps_pkg::ABORT_VALUE) begin
        search_phase = gsps_pkg::PH_IDLE;
        r.kind = gsps_pkg::KIND_ABORT;
        r.position = '0;
      end else begin
        if (search_phase == gsps_pkg::PH_FIRST) begin
          best_pos = probe_pos;
          best_val = v;
        end else begin
          fold_point(probe_pos, v);
        end
        next_probe(r);
      end
    end
  endtask

  always @(posedge clk) begin : track
    search_result_t want;
    search_result_t fresh;
    bit             produced;
    if (!rst_n) begin
      size_reg = 1;
      lo_pos = 1;
      hi_pos = 1;
      best_pos = '0;
      best_val = '0;
      probe_pos = '0;
      search_phase = gsps_pkg::PH_IDLE;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        case (out_tuser)
          gsps_pkg::KIND_PROBE:  probe_tally++;
          gsps_pkg::KIND_ANSWER: answer_tally++;
          gsps_pkg::KIND_ABORT:  abort_tally++;
          default:               ;
        endcase
        if (expected_results.size() == 0) begin
          fail_tally++;
          if (fail_tally <= REPORT_LIMIT)
            $display("%0t: unexpected result transfer: kind %0d position %0d",
                     $realtime, out_tuser, out_tdata[gsps_pkg::OUT_POS_W-1:0]);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind || out_tdata !== {3'b000, want.position}) begin
            fail_tally++;
            if (fail_tally <= REPORT_LIMIT)
              $display("%0t: result mismatch: kind exp %0d got %0d, %s %0d got %0d (tdata %h)",
                       $realtime, want.kind, out_tuser, "position exp", want.position,
                       out_tdata[gsps_pkg::OUT_POS_W-1:0], out_tdata);
          end
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        predict_item(in_tuser[0], in_tdata, produced, fresh);
        if (produced) expected_results.push_back(fresh);
      end
    end
    mismatch_count  <= fail_tally;
    pending_count   <= expected_results.size();
    probes_seen     <= probe_tally;
    answers_seen    <= answer_tally;
    aborts_seen     <= abort_tally;
    folds_predicted <= fold_tally;
  end

  initial begin
    fail_tally = 0;
    fold_tally = 0;
    probe_tally = 0;
    answer_tally = 0;
    abort_tally = 0;
  end

endmodule

// ===== bench/golden_section_peak_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golden_section_peak_search_test: testbench top of the peak search
// Drives start and response transfers, mostly as closed-loop searches that
// answer each probe from a random peak-shaped function, mixed with open-loop
// bursts of random traffic. Search sizes change between phases, and each
// phase picks an idle pattern for the sender, the receiver, both or neither.
// The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module golden_section_peak_search_test;

  localparam int POSITION_BITS = 20;
  localparam int MAX_SIZE      = 1 << POSITION_BITS;
  localparam int RESET_CYCLES  = 6;
  localparam int DRAIN_CYCLES  = 24;
  localparam int END_CYCLES    = 40;
  localparam int HOLD_CYCLES   = 400;

  localparam logic MODE_START    = 1'b0;
  localparam logic MODE_RESPONSE = 1'b1;

  localparam int SHAPE_TENT  = 0;
  localparam int SHAPE_FLAT  = 1;
  localparam int SHAPE_NOISE = 2;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH,
    IDLE_PRESSURE
  } idle_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [20:0] cfg_data   = 21'd1;

  int mismatch_count;
  int pending_count;
  int probes_seen;
  int answers_seen;
  int aborts_seen;
  int folds_predicted;

  idle_mode_t                     idle_mode = IDLE_NONE;
  int                             hold_left = 0;
  bit                             hold_used = 0;
  bit                             offering  = 0;
  logic [gsps_pkg::KIND_W-1:0]    last_kind = gsps_pkg::KIND_ANSWER;
  logic [gsps_pkg::OUT_POS_W-1:0] last_pos  = '0;
  int                             items_left;
  int                             items_sent = 0;
  int                             size_writes = 0;
  int                             cur_size = 1;
  int                             total_failures;

  // Shape of the function that answers probes in a closed-loop search.
  int                             shape;
  logic [gsps_pkg::OUT_POS_W-1:0] peak_pos;
  longint                         peak_top;
  longint                         slope;

  golden_section_peak_search #(
    .POSITION_BITS(POSITION_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  golden_section_peak_search_checker #(
    .POSITION_BITS(POSITION_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .probes_seen    (probes_seen),
    .answers_seen   (answers_seen),
    .aborts_seen    (aborts_seen),
    .folds_predicted(folds_predicted)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls per phase, plus one long hold-off under pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_used <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_mode == IDLE_PRESSURE && !hold_used) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_tready <= ($urandom_range(0, 99) >= 69);
        IDLE_BOTH: out_tready <= ($urandom_range(0, 99) >= 30);
        default:   out_tready <= 1'b1;
      endcase
    end
  end

  // The last result tells the closed-loop searches where the block stands.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      last_kind <= out_tuser;
      last_pos <= out_tdata[gsps_pkg::OUT_POS_W-1:0];
    end
  end

  initial begin
    #8_000_000;
    $display("golden_section_peak_search_test failed");
    $finish;
  end

  task automatic send_item(input logic mode, input logic [31:0] value);
    int gap_pct;
    case (idle_mode)
      IDLE_SEND: gap_pct = 69;
      IDLE_BOTH: gap_pct = 30;
      default:   gap_pct = 0;
    endcase
    while ($urandom_range(0, 99) < gap_pct) begin
      if (offering) begin
        in_tvalid <= 1'b0;
        offering = 0;
      end
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= value;
    offering = 1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic release_input();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 0;
    end
  endtask

  // An ignored response gives no result, so a fixed pause covers its cycles.
  task automatic drain();
    release_input();
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input int size);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= size[20:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_size = (size < 1) ? 1 : ((size > MAX_SIZE) ? MAX_SIZE : size);
    size_writes++;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 15);
      default: return $urandom() & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] value_at(input logic [gsps_pkg::OUT_POS_W-1:0] pos);
    longint distance;
    longint v;
    distance = (pos > peak_pos) ? pos - peak_pos : peak_pos - pos;
    case (shape)
      SHAPE_FLAT:  v = peak_top;
      SHAPE_NOISE: v = $urandom() & 32'h7FFF_FFFF;
      default:     v = peak_top - distance * slope;
    endcase
    if (v < 0) v = 0;
    return v[31:0];
  endfunction

  // Answers each probe after its result has come back; a search left open
  // at the end of a phase is continued under the next size setting.
  task automatic closed_session();
    int pick;
    pick = $urandom_range(0, 9);
    shape = (pick < 7) ? SHAPE_TENT : ((pick < 9) ? SHAPE_FLAT : SHAPE_NOISE);
    peak_pos = $urandom_range(0, cur_size + 1);
    peak_top = $urandom_range(1000, 32'h7FFF_FFFF);
    slope = $urandom_range(0, 3000);
    if (last_kind != gsps_pkg::KIND_PROBE || $urandom_range(0, 3) == 0) begin
      send_item(MODE_START, $urandom());
      items_left--;
    end
    while (items_left > 0) begin
      release_input();
      do @(posedge clk); while (pending_count != 0);
      if (last_kind != gsps_pkg::KIND_PROBE) break;
      pick = $urandom_range(0, 99);
      if (pick < 2) send_item(MODE_RESPONSE, gsps_pkg::ABORT_VALUE);
      else if (pick < 4) send_item(MODE_START, $urandom());
      else send_item(MODE_RESPONSE, value_at(last_pos));
      items_left--;
    end
  endtask

  task automatic open_burst(input int count);
    int k;
    int pick;
    for (k = 0; k < count && items_left > 0; k++) begin
      pick = $urandom_range(0, 99);
      if ((k == 0 && pick < 80) || pick < 6) send_item(MODE_START, $urandom());
      else if (pick < 10) send_item(MODE_RESPONSE, gsps_pkg::ABORT_VALUE);
      else send_item(MODE_RESPONSE, random_value());
      items_left--;
    end
  endtask

  task automatic run_phase(input int size, input idle_mode_t mode, input int count);
    write_size(size);
    idle_mode <= mode;
    items_left = count;
    while (items_left > 0) begin
      if ($urandom_range(0, 9) < 7) closed_session();
      else open_burst($urandom_range(5, 20));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Size 1 out of reset: an idle response is ignored, a start probes
    // position 1 and its first response answers at once.
    send_item(MODE_RESPONSE, 32'd7);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, 32'd0);
    send_item(MODE_RESPONSE, 32'd3);

    // Largest size: extreme values, restart mid-search, aborts in both phases.
    write_size(MAX_SIZE);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, 32'h7FFF_FFFF);
    send_item(MODE_RESPONSE, 32'd0);
    send_item(MODE_RESPONSE, 32'd0);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, gsps_pkg::ABORT_VALUE);
    send_item(MODE_RESPONSE, 32'd5);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, 32'd100);
    send_item(MODE_RESPONSE, 32'd100);
    send_item(MODE_RESPONSE, gsps_pkg::ABORT_VALUE);

    // Size 0 acts as 1; an oversize value is clamped.
    write_size(0);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, 32'd1);
    write_size(21'h1F_FFFF);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, 32'd9);
    send_item(MODE_RESPONSE, 32'd4);

    // Shrinking the size mid-search forces probes outside the range.
    write_size(1000);
    send_item(MODE_START, $urandom());
    send_item(MODE_RESPONSE, 32'd10);
    send_item(MODE_RESPONSE, 32'd20);
    write_size(3);
    send_item(MODE_RESPONSE, 32'd30);
    send_item(MODE_RESPONSE, 32'd40);
    send_item(MODE_RESPONSE, 32'd0);

    run_phase(1000, IDLE_NONE, 120);
    run_phase(MAX_SIZE, IDLE_SEND, 150);
    run_phase(37, IDLE_RECV, 120);
    run_phase(0, IDLE_BOTH, 100);
    run_phase(21'h1F_FFFF, IDLE_NONE, 120);
    run_phase(2, IDLE_BOTH, 80);
    run_phase($urandom_range(1, MAX_SIZE), IDLE_SEND, 120);
    run_phase($urandom_range(1, 300), IDLE_RECV, 120);
    run_phase(3, IDLE_NONE, 60);

    // The receiver holds off while the sender keeps offering transfers.
    write_size(500);
    idle_mode <= IDLE_PRESSURE;
    items_left = 60;
    open_burst(60);

    run_phase($urandom_range(1, MAX_SIZE), IDLE_BOTH, 150);

    release_input();
    do @(posedge clk); while (pending_count != 0);
    repeat (END_CYCLES) @(posedge clk);

    total_failures = mismatch_count + ((pending_count != 0) ? 1 : 0);
    $display("Run covered %0d input transfers over %0d size settings and all idle patterns.",
             items_sent, size_writes);
    $display("Results checked: %0d probe requests, %0d answers, %0d aborts; %0d probes folded.",
             probes_seen, answers_seen, aborts_seen, folds_predicted);
    if (total_failures == 0) begin
      $display("golden_section_peak_search_test passed");
    end else begin
      $display("golden_section_peak_search_test failed");
    end
    $finish;
  end

endmodule
